// ----- sv/ptqd_pkg.sv -----
`default_nettype none

package ptqd_pkg;

  // Queue depth (2..63) and the width of a fill count that can hold it
  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Internal time and sum widths: wide enough to wrap exactly like the output fields
  localparam int ELAPSED_W = 26;
  localparam int WAIT_W    = 25;
  localparam int TURN_W    = 26;
  localparam int TIME_W    = 21;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_SCHED = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADD_OK   = 2'd0,
    KIND_DROP     = 2'd1,
    KIND_DISPATCH = 2'd2,
    KIND_SUMMARY  = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] burst;
  } entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic   ins;   // sorted insert of item
    logic   shl;   // shift toward the head (drain)
    entry_t item;
  } cell_ctl_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] task_id;
    logic [7:0]  task_priority;
    logic [15:0] task_burst;
    logic [20:0] start_time;
    logic [20:0] finish_time;
    logic [5:0]  task_count;
    logic [24:0] total_wait;
    logic [25:0] total_turnaround;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/ptqd_cell.sv -----
`default_nettype none

// One queue slot. Holds its entry; on insert keeps, takes the new item or
// takes its left neighbor; on drain takes its right neighbor.
module ptqd_cell import ptqd_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,
  input  logic      keep_left,
  input  entry_t    left,
  input  entry_t    right,
  output logic      keep,
  output entry_t    ent
);

  // Stays put when occupied and not lower in priority (ties keep arrival order)
  assign keep = occ && (ent.prio >= ctl.item.prio);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (!keep) begin
        ent <= keep_left ? ctl.item : left;
      end
    end else if (ctl.shl) begin
      ent <= right;
    end
  end

endmodule

`default_nettype wire

// ----- sv/priority_task_queue_drain.sv -----
`default_nettype none

// Priority task queue with drain. Pulse start with busy low to issue a word:
// action 0 adds a task (priority_req, burst), action 1 schedules. An add
// answers with one result in the cycle after it is accepted (kind 0 with
// the new id, or kind 1 if the queue is full) and busy stays low, so adds
// can be issued every cycle. A schedule raises busy and drains the queue
// head first, one dispatch result per cycle from the cell at the head of
// the chain, followed by the summary with last set; busy drops in the
// cycle the summary appears. Every result is valid on the output ports
// for exactly the one cycle that strobe is high; there is no backpressure,
// so capture on strobe. The queue is a row of CAPACITY cells; an insert
// updates all cells together, steered by a combinational keep chain
// through the cells. Fields that do not apply to a kind read 0.
module priority_task_queue_drain import ptqd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [7:0]  priority_req,
  input  logic [15:0] burst,
  output logic        strobe,
  output logic [1:0]  kind,
  output logic [15:0] task_id,
  output logic [7:0]  task_priority,
  output logic [15:0] task_burst,
  output logic [20:0] start_time,
  output logic [20:0] finish_time,
  output logic [5:0]  task_count,
  output logic [24:0] total_wait,
  output logic [25:0] total_turnaround,
  output logic        last
);

  // Control state
  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;       // tasks in the queue
  logic [CNT_W-1:0]   remaining, remaining_next;
  logic [15:0]        next_id, next_id_next;
  logic               strobe_next;

  // Drain accumulators
  logic [ELAPSED_W-1:0] elapsed, elapsed_next;
  logic [WAIT_W-1:0]    wait_sum, wait_sum_next;
  logic [TURN_W-1:0]    turn_sum, turn_sum_next;
  logic [ELAPSED_W-1:0] fin;

  result_t   res, res_next;
  cell_ctl_t ctl;
  logic      full;

  entry_t               ents  [CAPACITY];
  logic [CAPACITY-1:0]  keeps;

  assign full = (count == CNT_W'(CAPACITY));
  assign busy = (state == ST_DRAIN);
  assign fin  = elapsed + ELAPSED_W'(ents[0].burst);

  // Cell chain: new item enters at cell 0's left, drain shifts toward cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   keep_left, occ;

    assign occ = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign left_ent  = ctl.item;
      assign keep_left = 1'b1;
    end else begin : g_body
      assign left_ent  = ents[i-1];
      assign keep_left = keeps[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_ent = ents[i];
    end else begin : g_mid
      assign right_ent = ents[i+1];
    end

    ptqd_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ),
      .keep_left (keep_left),
      .left      (left_ent),
      .right     (right_ent),
      .keep      (keeps[i]),
      .ent       (ents[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remaining <= '0;
      next_id   <= 16'd1;
      strobe    <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      next_id   <= next_id_next;
      strobe    <= strobe_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    elapsed  <= elapsed_next;
    wait_sum <= wait_sum_next;
    turn_sum <= turn_sum_next;
    res      <= res_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    next_id_next   = next_id;
    elapsed_next   = elapsed;
    wait_sum_next  = wait_sum;
    turn_sum_next  = turn_sum;
    strobe_next    = 1'b0;
    res_next       = res;
    ctl.ins        = 1'b0;
    ctl.shl        = 1'b0;
    ctl.item.id    = next_id;
    ctl.item.prio  = priority_req;
    ctl.item.burst = burst;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (action == ACT_ADD) begin
            strobe_next = 1'b1;
            res_next    = '0;
            res_next.last = 1'b1;
            if (full) begin
              res_next.kind = KIND_DROP;
            end else begin
              ctl.ins          = 1'b1;
              res_next.kind    = KIND_ADD_OK;
              res_next.task_id = next_id;
              next_id_next     = next_id + 16'd1;
              count_next       = count + CNT_W'(1);
            end
          end else begin
            state_next     = ST_DRAIN;
            remaining_next = count;
            elapsed_next   = '0;
            wait_sum_next  = '0;
            turn_sum_next  = '0;
          end
        end
      end
      ST_DRAIN: begin
        strobe_next = 1'b1;
        res_next    = '0;
        if (remaining != '0) begin
          // Head cell dispatches; rest of the chain moves up one slot
          ctl.shl                = 1'b1;
          res_next.kind          = KIND_DISPATCH;
          res_next.task_id       = ents[0].id;
          res_next.task_priority = ents[0].prio;
          res_next.task_burst    = ents[0].burst;
          res_next.start_time    = elapsed[TIME_W-1:0];
          res_next.finish_time   = fin[TIME_W-1:0];
          elapsed_next           = fin;
          wait_sum_next          = wait_sum + elapsed[WAIT_W-1:0];
          turn_sum_next          = turn_sum + fin[TURN_W-1:0];
          remaining_next         = remaining - CNT_W'(1);
        end else begin
          res_next.kind             = KIND_SUMMARY;
          res_next.task_count       = 6'(count);
          res_next.total_wait       = wait_sum;
          res_next.total_turnaround = turn_sum;
          res_next.last             = 1'b1;
          count_next                = '0;
          state_next                = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign kind             = res.kind;
  assign task_id          = res.task_id;
  assign task_priority    = res.task_priority;
  assign task_burst       = res.task_burst;
  assign start_time       = res.start_time;
  assign finish_time      = res.finish_time;
  assign task_count       = res.task_count;
  assign total_wait       = res.total_wait;
  assign total_turnaround = res.total_turnaround;
  assign last             = res.last;

  // Fill count never passes the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("queue count above capacity");

  // Dispatches are never last; every other kind closes its word
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (last == (kind != KIND_DISPATCH)))
    else $error("last flag does not match result kind");

  // A summary leaves the queue empty
  a_summary_empty: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == KIND_SUMMARY) |-> (count == '0))
    else $error("queue not empty after summary");

  // An accepted schedule word starts a drain
  a_sched_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (action == ACT_SCHED) |=> busy)
    else $error("schedule accepted without drain");

  // Remaining drain count never exceeds the fill count
  a_remaining: assert property (@(posedge clk) disable iff (rst)
    busy |-> (remaining <= count))
    else $error("drain count exceeds queue count");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import ptqd_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        action = ACT_ADD;
  logic [7:0]  priority_req = 8'd0;
  logic [15:0] burst = 16'd0;
  logic        strobe;
  logic [1:0]  kind;
  logic [15:0] task_id;
  logic [7:0]  task_priority;
  logic [15:0] task_burst;
  logic [20:0] start_time;
  logic [20:0] finish_time;
  logic [5:0]  task_count;
  logic [24:0] total_wait;
  logic [25:0] total_turnaround;
  logic        last;

  priority_task_queue_drain DUT (.*);

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Scheduler shadow: sorted task list, fill count and id counter, updated
  // whenever a word is accepted. Expected results wait in arrival order.
  // ---------------------------------------------------------------------------
  entry_t      task_list [CAPACITY];
  int          task_fill = 0;
  logic [15:0] id_counter = 16'd1;
  result_t     pending_results[$];

  int error_count    = 0;
  int words_sent     = 0;
  int results_seen   = 0;
  int drops_expected = 0;
  int drains_run     = 0;
  int max_drain      = 0;
  int cycle_count    = 0;
  int gap_pct        = 0;

  // Sorted insert: walk past every entry of equal or higher priority so
  // that ties keep arrival order. A full list drops the task, id unchanged.
  function automatic void predict_add(input logic [7:0] prio, input logic [15:0] len);
    result_t r;
    int      pos;
    r = '0;
    r.last = 1'b1;
    if (task_fill >= CAPACITY) begin
      r.kind = KIND_DROP;
      drops_expected++;
    end else begin
      pos = 0;
      while (pos < task_fill && task_list[pos].prio >= prio) pos++;
      for (int k = task_fill; k > pos; k--) task_list[k] = task_list[k - 1];
      task_list[pos].id    = id_counter;
      task_list[pos].prio  = prio;
      task_list[pos].burst = len;
      task_fill++;
      r.kind    = KIND_ADD_OK;
      r.task_id = id_counter;
      id_counter = id_counter + 16'd1;  // wraps 65535 -> 0
    end
    pending_results.push_back(r);
  endfunction

  // Drain head first; times run back to back from zero, sums kept in 32 bits
  // and cut to the port widths.
  function automatic void predict_drain();
    result_t     r;
    logic [31:0] elapsed;
    logic [31:0] wait_sum;
    logic [31:0] turn_sum;
    logic [31:0] fin;
    elapsed  = '0;
    wait_sum = '0;
    turn_sum = '0;
    for (int i = 0; i < task_fill; i++) begin
      fin = elapsed + {16'd0, task_list[i].burst};
      r = '0;
      r.kind          = KIND_DISPATCH;
      r.task_id       = task_list[i].id;
      r.task_priority = task_list[i].prio;
      r.task_burst    = task_list[i].burst;
      r.start_time    = elapsed[20:0];
      r.finish_time   = fin[20:0];
      pending_results.push_back(r);
      wait_sum += elapsed;
      turn_sum += fin;
      elapsed   = fin;
    end
    r = '0;
    r.kind             = KIND_SUMMARY;
    r.task_count       = task_fill[5:0];
    r.total_wait       = wait_sum[24:0];
    r.total_turnaround = turn_sum[25:0];
    r.last             = 1'b1;
    pending_results.push_back(r);
    if (task_fill > max_drain) max_drain = task_fill;
    drains_run++;
    task_fill = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe is matched against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_result
    result_t want;
    if (!rst && strobe === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d id %0d",
                 $time, kind, task_id);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind));
        check_field("task_id", 32'(want.task_id), 32'(task_id));
        check_field("task_priority", 32'(want.task_priority), 32'(task_priority));
        check_field("task_burst", 32'(want.task_burst), 32'(task_burst));
        check_field("start_time", 32'(want.start_time), 32'(start_time));
        check_field("finish_time", 32'(want.finish_time), 32'(finish_time));
        check_field("task_count", 32'(want.task_count), 32'(task_count));
        check_field("total_wait", 32'(want.total_wait), 32'(total_wait));
        check_field("total_turnaround", 32'(want.total_turnaround),
                    32'(total_turnaround));
        check_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_results.size());
      $display("priority_task_queue_drain test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Word driver. Drives at the falling edge, holds start until a rising edge
  // sees busy low, then updates the shadow. start is left high on return so
  // back-to-back words keep it asserted; callers lower it via hold_start_low.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic act, input logic [7:0] prio,
                           input logic [15:0] len);
    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(7, 0)) @(negedge clk);
    end
    @(negedge clk);
    start        <= 1'b1;
    action       <= act;
    priority_req <= prio;
    burst        <= len;
    do @(posedge clk); while (busy !== 1'b0);
    words_sent++;
    if (act == ACT_ADD) predict_add(prio, len);
    else predict_drain();
  endtask

  task automatic hold_start_low();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Stop sending and wait until every expected word has come back.
  task automatic wait_drained();
    hold_start_low();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [7:0] random_priority();
    // half the time from a coarse set so ties are common
    if ($urandom_range(1, 0) == 0) return 8'($urandom_range(3, 0) * 85);
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] random_burst();
    int pick;
    pick = $urandom_range(9, 0);
    if (pick < 6) return 16'($urandom);
    if (pick < 8) return 16'($urandom_range(15, 0));
    return (pick == 8) ? 16'd0 : 16'hFFFF;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Schedule with nothing queued: summary only, all zero. Twice in a row.
  task automatic test_empty_schedule();
    send_word(ACT_SCHED, 8'hFF, 16'hFFFF);
    send_word(ACT_SCHED, 8'h00, 16'h0000);
  endtask

  // Priority extremes, ties at both ends, burst extremes; then drain.
  task automatic test_priority_order();
    send_word(ACT_ADD, 8'd128, 16'd100);
    send_word(ACT_ADD, 8'd255, 16'd0);
    send_word(ACT_ADD, 8'd0,   16'hFFFF);
    send_word(ACT_ADD, 8'd128, 16'd7);
    send_word(ACT_ADD, 8'd255, 16'd1);
    send_word(ACT_ADD, 8'd0,   16'd0);
    send_word(ACT_ADD, 8'd1,   16'hAAAA);
    send_word(ACT_ADD, 8'd254, 16'h5555);
    send_word(ACT_SCHED, 8'h5A, 16'hA5A5);
  endtask

  // Fill to capacity with maximum bursts (largest times and sums), two
  // drops on the full queue, then the longest drain.
  task automatic test_full_queue();
    while (task_fill < CAPACITY) send_word(ACT_ADD, random_priority(), 16'hFFFF);
    send_word(ACT_ADD, 8'd255, 16'd1);
    send_word(ACT_ADD, 8'd0,   16'd2);
    send_word(ACT_SCHED, 8'd0, 16'd0);
  endtask

  // Mostly adds with occasional drains; now and then a flood that fills
  // the queue and overflows it by one.
  task automatic test_random_mix(input int idle_pct, input int n_words,
                                 input bit pause_midway);
    int  sent;
    int  roll;
    bit  paused;
    sent    = 0;
    paused  = 1'b0;
    gap_pct = idle_pct;
    while (sent < n_words) begin
      if (pause_midway && !paused && sent >= n_words / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      roll = $urandom_range(99, 0);
      if (roll < 12) begin
        send_word(ACT_SCHED, 8'($urandom), 16'($urandom));
        sent++;
      end else if (roll < 15) begin
        while (task_fill < CAPACITY) begin
          send_word(ACT_ADD, random_priority(), random_burst());
          sent++;
        end
        send_word(ACT_ADD, random_priority(), random_burst());
        sent++;
      end else begin
        send_word(ACT_ADD, random_priority(), random_burst());
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_empty_schedule();
    test_priority_order();
    test_full_queue();
    wait_drained();

    // sender idles rarely, then mostly, then never (with a full pause)
    test_random_mix(7, 60, 1'b0);
    test_random_mix(79, 60, 1'b0);
    test_random_mix(0, 60, 1'b1);
    send_word(ACT_SCHED, 8'd0, 16'd0);

    wait_drained();
    repeat (10) @(posedge clk);

    $display("Sent %0d words (%0d schedules, longest drain %0d tasks, %0d drops);",
             words_sent, drains_run, max_drain, drops_expected);
    $display("checked %0d results over ties, full-queue drops and sender gaps.",
             results_seen);
    if (error_count == 0) begin
      $display("priority_task_queue_drain test passed");
    end else begin
      $display("priority_task_queue_drain test failed");
    end
    $finish;
  end

endmodule
